[hdl/nsf_pkg.sv]
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants and helpers for the NMEA sentence framer: character
// codes, class codes, sentence type codes and the type name table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsf_pkg;

  // widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ClassW   = 3;
  localparam int unsigned TypeW    = 3;
  localparam int unsigned NumTypes = 6;
  localparam int unsigned CfgIdxW  = 2;

  // special characters
  localparam logic [ByteW-1:0] ChrNul    = 8'h00;
  localparam logic [ByteW-1:0] ChrDollar = 8'h24;
  localparam logic [ByteW-1:0] ChrComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChrStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChrCr     = 8'h0D;

  // character classes
  localparam logic [ClassW-1:0] ClsData     = 3'd0;
  localparam logic [ClassW-1:0] ClsStart    = 3'd1;
  localparam logic [ClassW-1:0] ClsFieldEnd = 3'd2;
  localparam logic [ClassW-1:0] ClsSentEnd  = 3'd3;
  localparam logic [ClassW-1:0] ClsIgnored  = 3'd4;

  // sentence types
  localparam logic [TypeW-1:0] TypeUnknown = 3'd0;
  localparam logic [TypeW-1:0] TypeGsv     = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRequired = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEnabled  = 2'd1;

  // type names, entry t holds type t+1 as three characters
  localparam logic [3*ByteW-1:0] TypeNames [NumTypes] = '{
    {8'h47, 8'h47, 8'h41},  // GGA
    {8'h47, 8'h53, 8'h41},  // GSA
    {8'h52, 8'h4D, 8'h43},  // RMC
    {8'h47, 8'h53, 8'h56},  // GSV
    {8'h47, 8'h4C, 8'h4C},  // GLL
    {8'h56, 8'h54, 8'h47}   // VTG
  };

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // lowest set bit of a type mask as a type code, unknown when empty
  function automatic logic [TypeW-1:0] first_type(input logic [NumTypes-1:0] m);
    logic [TypeW-1:0] r;
    logic             found;
    r     = TypeUnknown;
    found = 1'b0;
    for (int i = 0; i < NumTypes; i++) begin
      if (m[i] && !found) begin
        r     = TypeW'(i + 1);
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

[hdl/nmea_sentence_framer.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// Each accepted item's result is registered in the output register in the next cycle.
// Throughput: one item per cycle; the output register frees as its result is taken.
// Reset: all framing state, the seen mask and the output valid clear; both type
// masks reset to all six types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_sentence_framer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nsf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [nsf_pkg::NumTypes-1:0]   cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [nsf_pkg::ByteW-1:0]      rx_byte_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [nsf_pkg::ClassW-1:0]     char_class_o,
  output logic [nsf_pkg::ByteW-1:0]      field_index_o,
  output logic [nsf_pkg::TypeW-1:0]      sentence_type_o,
  output logic                           checksum_ok_o,
  output logic                           gsv_last_part_o,
  output logic                           all_required_seen_o
);
  import nsf_pkg::*;

  // configuration
  logic [NumTypes-1:0] required_q, enabled_q;

  // framing state
  logic [ByteW-1:0]    xor_q, xor_d;
  logic                after_star_q, after_star_d;
  logic [ByteW-1:0]    field_count_q, field_count_d;
  logic [TypeW-1:0]    cur_type_q, cur_type_d;
  logic [2*ByteW-1:0]  window_q, window_d;
  logic [1:0]          window_fill_q, window_fill_d;
  logic [NumTypes-1:0] type_hits_q, type_hits_d;
  logic                starts_dollar_q, starts_dollar_d;
  logic [ByteW-1:0]    hex_q, hex_d;
  logic                hex_stop_q, hex_stop_d;
  logic [ByteW-1:0]    dec_q, dec_d;
  logic                dec_stop_q, dec_stop_d;
  logic [ByteW-1:0]    part_count_q, part_count_d;
  logic [ByteW-1:0]    part_num_q, part_num_d;
  logic [NumTypes-1:0] seen_q, seen_d;

  // result register
  logic                out_valid_q;
  logic [ClassW-1:0]   cls_q, cls_d;
  logic [ByteW-1:0]    idx_q, idx_d;
  logic [TypeW-1:0]    type_out_q;
  logic                ok_q, ok_d;
  logic                last_q, last_d;
  logic                done_q, done_d;

  logic                accept;
  logic [4:0]          hex_dig;
  logic                is_dec;
  logic [ByteW-1:0]    dec_next;
  logic                gsv_live;
  logic [NumTypes-1:0] seen_set;
  logic [NumTypes-1:0] new_hits;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      required_q <= '1;
      enabled_q  <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegRequired) begin
        required_q <= cfg_data_i;
      end
      if (cfg_index_i == RegEnabled) begin
        enabled_q <= cfg_data_i;
      end
    end
  end

  // per-character helpers
  assign hex_dig  = hex_digit(rx_byte_i);
  assign is_dec   = rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39;
  assign dec_next = (dec_q << 3) + (dec_q << 1) + {4'd0, rx_byte_i[3:0]};
  assign gsv_live = cur_type_q == TypeGsv && enabled_q[TypeGsv-1];

  // sliding window compare against the type names
  always_comb begin
    for (int t = 0; t < NumTypes; t++) begin
      new_hits[t] = TypeNames[t] == {window_q, rx_byte_i};
    end
  end

  // next state and result for one character
  always_comb begin
    xor_d           = xor_q;
    after_star_d    = after_star_q;
    field_count_d   = field_count_q;
    cur_type_d      = cur_type_q;
    window_d        = window_q;
    window_fill_d   = window_fill_q;
    type_hits_d     = type_hits_q;
    starts_dollar_d = starts_dollar_q;
    hex_d           = hex_q;
    hex_stop_d      = hex_stop_q;
    dec_d           = dec_q;
    dec_stop_d      = dec_stop_q;
    part_count_d    = part_count_q;
    part_num_d      = part_num_q;
    seen_d          = seen_q;
    seen_set        = seen_q;
    cls_d           = ClsData;
    idx_d           = field_count_q;
    ok_d            = 1'b0;
    last_d          = 1'b0;
    done_d          = 1'b0;

    priority if (rx_byte_i == ChrNul) begin
      cls_d = ClsIgnored;
    end else if (rx_byte_i == ChrDollar) begin
      // sentence start: clear framing, field 0 begins with the start mark
      cls_d           = ClsStart;
      idx_d           = '0;
      after_star_d    = 1'b0;
      field_count_d   = '0;
      cur_type_d      = TypeUnknown;
      xor_d           = '0;
      part_count_d    = '0;
      part_num_d      = '0;
      window_d        = '0;
      window_fill_d   = '0;
      type_hits_d     = '0;
      starts_dollar_d = 1'b1;
      hex_d           = '0;
      hex_stop_d      = 1'b1;
      dec_d           = '0;
      dec_stop_d      = 1'b1;
    end else if (rx_byte_i == ChrComma || rx_byte_i == ChrStar) begin
      // field end: resolve type on field 0, capture gsv counts
      cls_d = ClsFieldEnd;
      if (field_count_q == '0 && starts_dollar_q) begin
        cur_type_d = first_type(type_hits_q & enabled_q);
      end else if (gsv_live) begin
        if (field_count_q == 8'd1) begin
          part_count_d = dec_q;
        end else if (field_count_q == 8'd2) begin
          part_num_d = dec_q;
        end
      end
      if (rx_byte_i == ChrComma) begin
        xor_d = xor_q ^ rx_byte_i;
      end else begin
        after_star_d = 1'b1;
      end
      window_d        = '0;
      window_fill_d   = '0;
      type_hits_d     = '0;
      starts_dollar_d = 1'b0;
      hex_d           = '0;
      hex_stop_d      = 1'b0;
      dec_d           = '0;
      dec_stop_d      = 1'b0;
      field_count_d   = field_count_q + 8'd1;
    end else if (rx_byte_i == ChrCr) begin
      // sentence end: checksum, gsv part check, seen mask update
      cls_d  = ClsSentEnd;
      last_d = gsv_live && part_num_q == part_count_q;
      ok_d   = xor_q == hex_q;
      if (ok_d) begin
        if (cur_type_q != TypeUnknown && enabled_q[cur_type_q-TypeW'(1)] &&
            (cur_type_q != TypeGsv || last_d)) begin
          seen_set[cur_type_q-TypeW'(1)] = 1'b1;
        end
        if ((seen_set & required_q) == required_q) begin
          seen_d = '0;
          done_d = 1'b1;
        end else begin
          seen_d = seen_set;
        end
      end
    end else begin
      // data character
      if (!after_star_q) begin
        xor_d = xor_q ^ rx_byte_i;
      end
      if (window_fill_q >= 2'd2) begin
        type_hits_d = type_hits_q | new_hits;
      end else begin
        window_fill_d = window_fill_q + 2'd1;
      end
      window_d = {window_q[ByteW-1:0], rx_byte_i};
      if (!hex_stop_q) begin
        if (hex_dig[4]) begin
          hex_d = {hex_q[3:0], hex_dig[3:0]};
        end else begin
          hex_stop_d = 1'b1;
        end
      end
      if (!dec_stop_q) begin
        if (is_dec) begin
          dec_d = dec_next;
        end else begin
          dec_stop_d = 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q           <= '0;
      after_star_q    <= 1'b0;
      field_count_q   <= '0;
      cur_type_q      <= TypeUnknown;
      window_q        <= '0;
      window_fill_q   <= '0;
      type_hits_q     <= '0;
      starts_dollar_q <= 1'b0;
      hex_q           <= '0;
      hex_stop_q      <= 1'b0;
      dec_q           <= '0;
      dec_stop_q      <= 1'b0;
      part_count_q    <= '0;
      part_num_q      <= '0;
      seen_q          <= '0;
    end else if (accept) begin
      xor_q           <= xor_d;
      after_star_q    <= after_star_d;
      field_count_q   <= field_count_d;
      cur_type_q      <= cur_type_d;
      window_q        <= window_d;
      window_fill_q   <= window_fill_d;
      type_hits_q     <= type_hits_d;
      starts_dollar_q <= starts_dollar_d;
      hex_q           <= hex_d;
      hex_stop_q      <= hex_stop_d;
      dec_q           <= dec_d;
      dec_stop_q      <= dec_stop_d;
      part_count_q    <= part_count_d;
      part_num_q      <= part_num_d;
      seen_q          <= seen_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q      <= cls_d;
      idx_q      <= idx_d;
      type_out_q <= cur_type_d;
      ok_q       <= ok_d;
      last_q     <= last_d;
      done_q     <= done_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign char_class_o        = cls_q;
  assign field_index_o       = idx_q;
  assign sentence_type_o     = type_out_q;
  assign checksum_ok_o       = ok_q;
  assign gsv_last_part_o     = last_q;
  assign all_required_seen_o = done_q;

  // completion only on a sentence end that passed its checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_required_seen_o |-> char_class_o == ClsSentEnd && checksum_ok_o)
    else $error("completion without a passing sentence end");

  // last part flag only for a gsv sentence end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gsv_last_part_o |-> char_class_o == ClsSentEnd &&
                                       sentence_type_o == TypeGsv)
    else $error("gsv last part outside a gsv sentence end");

  // a start mark leaves field 0 with stopped value parsers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rx_byte_i == ChrDollar |=> field_count_q == '0 && hex_stop_q &&
                                        dec_stop_q && cur_type_q == TypeUnknown)
    else $error("start mark did not reset framing");

  // completion leaves the seen mask empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && done_d |=> seen_q == '0)
    else $error("seen mask not cleared on completion");

endmodule

[tb/nmea_sentence_framer_test.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_framer_test
// Self-checking testbench for the NMEA sentence framer. A scoreboard class
// tracks the framing state and predicts the result of every accepted byte.
// Each result that leaves the block is checked in order against that
// prediction. The stimulus starts with a short directed part, then runs
// well-formed sentences, broken sentences and noise under several type mask
// settings. Both channels stall at random, and there is one long hold-off on
// the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// sentence type tags, entry t holds the three letters of type t+1
localparam logic [23:0] SentenceTags [6] = '{"GGA", "GSA", "RMC", "GSV", "GLL", "VTG"};

typedef enum logic [2:0] {
  SenUnknown = 3'd0,
  SenGga     = 3'd1,
  SenGsa     = 3'd2,
  SenRmc     = 3'd3,
  SenGsv     = 3'd4,
  SenGll     = 3'd5,
  SenVtg     = 3'd6
} sentence_e;

typedef struct packed {
  logic [nsf_pkg::ClassW-1:0] char_class;
  logic [nsf_pkg::ByteW-1:0]  field_index;
  logic [nsf_pkg::TypeW-1:0]  sentence_type;
  logic                       checksum_ok;
  logic                       gsv_last_part;
  logic                       all_required_seen;
} frame_result_t;

class framer_scoreboard;
  // type masks
  logic [5:0]    required_mask;
  logic [5:0]    enabled_mask;
  // sentence state
  logic [7:0]    xor_acc;
  logic          past_star;
  logic [7:0]    field_cnt;
  sentence_e     cur_type;
  logic [7:0]    part_total;
  logic [7:0]    part_index;
  logic [5:0]    seen_mask;
  // field state
  logic [15:0]   window;
  logic [1:0]    window_fill;
  logic [5:0]    tag_hits;
  logic          opened_by_dollar;
  logic [7:0]    hex_acc;
  logic          hex_done;
  logic [7:0]    dec_acc;
  logic          dec_done;
  // predicted results, oldest first
  frame_result_t expected_q [$];
  int unsigned   mismatches;

  function new();
    required_mask = 6'h3F;
    enabled_mask  = 6'h3F;
    xor_acc       = '0;
    past_star     = 1'b0;
    field_cnt     = '0;
    cur_type      = SenUnknown;
    part_total    = '0;
    part_index    = '0;
    seen_mask     = '0;
    mismatches    = 0;
    clear_field();
  endfunction

  function void set_reg(input logic [nsf_pkg::CfgIdxW-1:0] idx, input logic [5:0] data);
    case (idx)
      nsf_pkg::RegRequired: required_mask = data;
      nsf_pkg::RegEnabled:  enabled_mask  = data;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function logic type_on(input sentence_e t);
    if (t == SenUnknown || t > SenVtg) return 1'b0;
    return enabled_mask[int'(t) - 1];
  endfunction

  function void clear_field();
    window           = '0;
    window_fill      = '0;
    tag_hits         = '0;
    opened_by_dollar = 1'b0;
    hex_acc          = '0;
    hex_done         = 1'b0;
    dec_acc          = '0;
    dec_done         = 1'b0;
  endfunction

  // field 0 picks the type, GSV fields 1 and 2 give the part counts
  function void close_field();
    logic found;
    found = 1'b0;
    if (field_cnt == 8'd0 && opened_by_dollar) begin
      cur_type = SenUnknown;
      for (int t = 1; t <= 6; t++) begin
        if (!found && tag_hits[t-1] && type_on(sentence_e'(t))) begin
          cur_type = sentence_e'(t);
          found    = 1'b1;
        end
      end
    end else if (cur_type == SenGsv && type_on(SenGsv)) begin
      if (field_cnt == 8'd1) part_total = dec_acc;
      else if (field_cnt == 8'd2) part_index = dec_acc;
    end
  endfunction

  function void take_data(input logic [7:0] c);
    if (!past_star) xor_acc ^= c;
    // tag window
    if (window_fill >= 2'd2) begin
      for (int t = 0; t < 6; t++) begin
        if ({window, c} == SentenceTags[t]) tag_hits[t] = 1'b1;
      end
    end else begin
      window_fill++;
    end
    window = {window[7:0], c};
    // hex value
    if (!hex_done) begin
      if (c >= "0" && c <= "9") hex_acc = {hex_acc[3:0], c[3:0]};
      else if (c >= "A" && c <= "F") hex_acc = {hex_acc[3:0], 4'(c - "A" + 8'd10)};
      else if (c >= "a" && c <= "f") hex_acc = {hex_acc[3:0], 4'(c - "a" + 8'd10)};
      else hex_done = 1'b1;
    end
    // decimal value
    if (!dec_done) begin
      if (c >= "0" && c <= "9") dec_acc = dec_acc * 8'd10 + (c - "0");
      else dec_done = 1'b1;
    end
  endfunction

  // predict the result of one accepted byte
  function void note_byte(input logic [7:0] c);
    frame_result_t r;
    r             = '0;
    r.field_index = field_cnt;
    if (c == nsf_pkg::ChrNul) begin
      r.char_class = nsf_pkg::ClsIgnored;
    end else if (c == nsf_pkg::ChrDollar) begin
      r.char_class = nsf_pkg::ClsStart;
      past_star    = 1'b0;
      field_cnt    = '0;
      cur_type     = SenUnknown;
      xor_acc      = '0;
      part_total   = '0;
      part_index   = '0;
      clear_field();
      opened_by_dollar = 1'b1;
      hex_done         = 1'b1;
      dec_done         = 1'b1;
      r.field_index    = '0;
    end else if (c == nsf_pkg::ChrComma || c == nsf_pkg::ChrStar) begin
      r.char_class = nsf_pkg::ClsFieldEnd;
      close_field();
      if (c == nsf_pkg::ChrComma) xor_acc ^= c;
      else past_star = 1'b1;
      clear_field();
      field_cnt++;
    end else if (c == nsf_pkg::ChrCr) begin
      r.char_class    = nsf_pkg::ClsSentEnd;
      r.gsv_last_part = cur_type == SenGsv && type_on(SenGsv) && part_index == part_total;
      r.checksum_ok   = xor_acc == hex_acc;
      if (r.checksum_ok) begin
        if (type_on(cur_type) && (cur_type != SenGsv || r.gsv_last_part)) begin
          seen_mask[int'(cur_type) - 1] = 1'b1;
        end
        if ((seen_mask & required_mask) == required_mask) begin
          seen_mask           = '0;
          r.all_required_seen = 1'b1;
        end
      end
    end else begin
      take_data(c);
    end
    r.sentence_type = cur_type;
    expected_q.push_back(r);
  endfunction

  function void flag(input string what, input frame_result_t want, input frame_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d: %s", mismatches, what);
      $display("  expected class %0d field %0d type %0d ok %0b last %0b done %0b",
               want.char_class, want.field_index, want.sentence_type,
               want.checksum_ok, want.gsv_last_part, want.all_required_seen);
      $display("  actual   class %0d field %0d type %0d ok %0b last %0b done %0b",
               got.char_class, got.field_index, got.sentence_type,
               got.checksum_ok, got.gsv_last_part, got.all_required_seen);
    end
  endfunction

  function void check_result(input frame_result_t got);
    frame_result_t want;
    if (expected_q.size() == 0) begin
      flag("result with no byte pending", '0, got);
    end else begin
      want = expected_q.pop_front();
      if (got !== want) flag("result differs", want, got);
    end
  endfunction
endclass

module nmea_sentence_framer_test;
  import nsf_pkg::*;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 9;
  localparam int WatchdogLimit = 2000;
  localparam int RxHoldCycles  = 150;
  localparam int DrainCycles   = 4;
  localparam int NumPhases     = 8;
  localparam int PhaseBytes    = 130;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [NumTypes-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ByteW-1:0]    rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ClassW-1:0]   char_class_o;
  logic [ByteW-1:0]    field_index_o;
  logic [TypeW-1:0]    sentence_type_o;
  logic                checksum_ok_o;
  logic                gsv_last_part_o;
  logic                all_required_seen_o;

  framer_scoreboard board;
  logic [7:0]       text_q [$];
  int unsigned      bytes_sent    = 0;
  int unsigned      idle_cycles   = 0;
  int unsigned      hold_requests = 0;
  logic             tx_calm       = 1'b0;
  logic             rx_calm       = 1'b0;

  nmea_sentence_framer u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .char_class_o       (char_class_o),
    .field_index_o      (field_index_o),
    .sentence_type_o    (sentence_type_o),
    .checksum_ok_o      (checksum_ok_o),
    .gsv_last_part_o    (gsv_last_part_o),
    .all_required_seen_o(all_required_seen_o)
  );

  // clock
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // check results, then note accepted bytes
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      board.check_result({char_class_o, field_index_o, sentence_type_o,
                          checksum_ok_o, gsv_last_part_o, all_required_seen_o});
    end
    if (in_valid_i && in_ready_o) board.note_byte(rx_byte_i);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // gap lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls and the long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left  = 0;
    holds_done  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready_i = 1'b0;
        repeat (RxHoldCycles - 1) @(negedge clk_i);
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  // offer one byte and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (b != ChrNul) bytes_sent++;
    @(negedge clk_i);
    if (!tx_calm && $urandom_range(0, 99) < 18) begin
      in_valid_i = 1'b0;
      repeat (pick_gap()) @(negedge clk_i);
    end
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_byte(text_q.pop_front());
  endtask

  // wait until every predicted result has come back
  task automatic settle();
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [5:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_tag(input int t);
    text_q.push_back(SentenceTags[t][23:16]);
    text_q.push_back(SentenceTags[t][15:8]);
    text_q.push_back(SentenceTags[t][7:0]);
  endfunction

  function automatic logic [7:0] text_xor(input int from);
    logic [7:0] acc;
    acc = '0;
    for (int i = from; i < text_q.size(); i++) acc ^= text_q[i];
    return acc;
  endfunction

  // low two digits carry the value, a third one in front is random
  function automatic void push_hex(input logic [7:0] v, input int digits, input logic lower);
    logic [3:0] nib;
    for (int i = digits - 1; i >= 0; i--) begin
      nib = (i < 2) ? 4'(v >> (4 * i)) : 4'($urandom_range(0, 15));
      if (nib < 4'd10) text_q.push_back("0" + 8'(nib));
      else text_q.push_back((lower ? "a" : "A") + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic logic [7:0] pick_data_char();
    string      pool;
    logic [7:0] c;
    pool = "0123456789ABCDEFabcdef.-+ NSEWMKTGPVLRx/";
    if ($urandom_range(0, 99) < 6) begin
      c = 8'($urandom_range(1, 255));
      if (c == ChrDollar || c == ChrComma || c == ChrStar || c == ChrCr) c = 8'h7E;
      return c;
    end
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // one sentence with random content, mostly with a correct checksum
  function automatic void add_sentence(input logic many_fields);
    int         start;
    int         t;
    int         r;
    int         nf;
    int         cnt;
    int         num;
    string      letters;
    logic [7:0] sum;
    letters = "GSAVTLRMCP";
    text_q.push_back(ChrDollar);
    start = text_q.size();
    t     = $urandom_range(0, 5);
    // field 0
    r = $urandom_range(0, 99);
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0: push_text("GP");
        1: push_text("GN");
        2: push_text("GL");
        default: push_text("BD");
      endcase
      push_tag(t);
    end else if (r < 82) begin
      push_tag(t);
    end else if (r < 90) begin
      push_tag($urandom_range(0, 5));
      push_tag(t);
    end else if (r < 96) begin
      repeat ($urandom_range(3, 7)) text_q.push_back(letters[$urandom_range(0, 9)]);
    end
    // gsv part count and part number
    if (t == 3 && !many_fields) begin
      cnt = $urandom_range(1, 4);
      num = ($urandom_range(0, 99) < 60) ? cnt : $urandom_range(1, cnt);
      if ($urandom_range(0, 99) < 8) cnt += 254;
      text_q.push_back(ChrComma);
      push_text($sformatf("%0d", cnt));
      text_q.push_back(ChrComma);
      push_text($sformatf("%0d", num));
      if ($urandom_range(0, 99) < 10) push_text("x");
    end
    // remaining fields
    nf = many_fields ? 262 : $urandom_range(0, 4);
    for (int i = 0; i < nf; i++) begin
      text_q.push_back(ChrComma);
      if (!many_fields) begin
        repeat (($urandom_range(0, 99) < 2) ? $urandom_range(40, 160) : $urandom_range(0, 4))
          text_q.push_back(pick_data_char());
      end
    end
    // checksum
    sum = text_xor(start);
    r   = $urandom_range(0, 99);
    if (r < 8) sum ^= 8'($urandom_range(1, 255));
    if (r < 8 || r >= 12) begin
      text_q.push_back(ChrStar);
      push_hex(sum, (r >= 12 && r < 16) ? 3 : ((r >= 16 && r < 19) ? 1 : 2),
               1'($urandom_range(0, 1)));
    end
    text_q.push_back(ChrCr);
    if ($urandom_range(0, 99) < 90) text_q.push_back(8'h0A);
    // stray characters after the sentence end
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(pick_data_char());
      if ($urandom_range(0, 1) == 1) text_q.push_back(ChrComma);
    end
  endfunction

  function automatic void add_noise();
    int r;
    repeat ($urandom_range(1, 10)) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        text_q.push_back(ChrNul);
      end else if (r < 30) begin
        case ($urandom_range(0, 3))
          0: text_q.push_back(ChrDollar);
          1: text_q.push_back(ChrComma);
          2: text_q.push_back(ChrStar);
          default: text_q.push_back(ChrCr);
        endcase
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // stimulus
  initial begin
    logic [7:0]  sum;
    int unsigned phase_end;
    int          r;
    board       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegRequired;
    cfg_data_i  = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // bytes outside any sentence: ignored zero, top values, a bare end
    text_q.push_back(ChrNul);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    text_q.push_back(ChrCr);
    send_text();

    // unknown sentence passing with an empty required set completes
    settle();
    write_reg(RegRequired, 6'h00);
    push_text("$*00");
    text_q.push_back(ChrCr);
    send_text();

    // gsv disabled after it was matched
    push_text("$GSV,2,2");
    sum = text_xor(1);
    send_text();
    settle();
    write_reg(RegEnabled, 6'h37);
    text_q.push_back(ChrStar);
    push_hex(sum, 2, 1'b0);
    text_q.push_back(ChrCr);
    send_text();

    // random phases, each under its own mask setting
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin write_reg(RegRequired, 6'h3F); write_reg(RegEnabled, 6'h3F); end
        1: begin write_reg(RegRequired, 6'h00); write_reg(RegEnabled, 6'h3F); end
        2: begin write_reg(RegRequired, 6'h01); write_reg(RegEnabled, 6'h3F); end
        3: begin write_reg(RegRequired, 6'h3F); write_reg(RegEnabled, 6'h00); end
        5: begin write_reg(RegRequired, 6'h08); write_reg(RegEnabled, 6'h3F); end
        6: begin write_reg(RegRequired, 6'($urandom_range(0, 63))); write_reg(RegEnabled, 6'h2A); end
        7: begin write_reg(RegRequired, 6'h3F); write_reg(RegEnabled, 6'($urandom_range(0, 63))); end
        default: begin
          write_reg(RegRequired, 6'($urandom_range(0, 63)));
          write_reg(RegEnabled, 6'($urandom_range(0, 63)));
        end
      endcase
      tx_calm = (p == 4);
      rx_calm = (p == 4);
      if (p == 2) hold_requests++;
      // field counter wraps past 255
      if (p == 5) begin
        add_sentence(1'b1);
        send_text();
      end
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 82) begin
          add_sentence(1'b0);
          if ($urandom_range(0, 99) < 5) text_q.insert($urandom_range(0, text_q.size()), ChrNul);
        end else if (r < 92) begin
          add_noise();
        end else begin
          // cut short, the next start mark restarts framing
          add_sentence(1'b0);
          r = $urandom_range(1, text_q.size() - 1);
          while (text_q.size() > r) void'(text_q.pop_back());
        end
        send_text();
      end
    end

    // drain and finish
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
